// ===== sv/ats_pkg.sv =====
`default_nettype none

package ats_pkg;

    localparam int unsigned CfgIndexWidth = 3;
    localparam int unsigned CfgDataWidth  = 32;
    localparam int unsigned TickWidth     = 32;
    localparam int unsigned CountWidth    = 16;
    localparam int unsigned ElapsedWidth  = 16;

    typedef logic [CfgIndexWidth-1:0] cfg_index_t;
    typedef logic [1:0]               msg_t;
    typedef logic [1:0]               blink_t;

    localparam cfg_index_t REG_SUP_PERIOD   = 3'd0;
    localparam cfg_index_t REG_SUP_ENABLED  = 3'd1;
    localparam cfg_index_t REG_RESTORE      = 3'd2;
    localparam cfg_index_t REG_BOOT_IGNORE  = 3'd3;
    localparam cfg_index_t REG_ALARM_CREDIT = 3'd4;
    localparam cfg_index_t REG_TEST_CREDIT  = 3'd5;

    localparam msg_t ALARM_NONE = 2'd0;
    localparam msg_t ALARM_SENT = 2'd1;
    localparam msg_t ALARM_TEST = 2'd2;

    localparam msg_t TAMPER_NONE    = 2'd0;
    localparam msg_t TAMPER_SENT    = 2'd1;
    localparam msg_t TAMPER_RESTORE = 2'd2;

    localparam blink_t BLINK_NONE   = 2'd0;
    localparam blink_t BLINK_NORMAL = 2'd1;
    localparam blink_t BLINK_LOW    = 2'd3;

    localparam logic [TickWidth-1:0]  RST_SUP_PERIOD   = 32'd3600000;
    localparam logic                  RST_SUP_ENABLED  = 1'b1;
    localparam logic [CountWidth-1:0] RST_RESTORE      = 16'd9375;
    localparam logic [CountWidth-1:0] RST_BOOT_IGNORE  = 16'd100;
    localparam logic [CountWidth-1:0] RST_ALARM_CREDIT = 16'd2400;
    localparam logic [CountWidth-1:0] RST_TEST_CREDIT  = 16'd900;

endpackage

`default_nettype wire

// ===== sv/alarm_tamper_supervisor.sv =====
// Channel | Handshake             | Payload
// input   | in_valid / in_ready   | alarm_level .. ticks_elapsed (one polling pass)
// output  | out_valid / out_ready | alarm_message .. led_force_off (one result)
// config  | cfg_we                | cfg_index, cfg_data
// Two register stages: an input register and a result register, with the state
// update between them. One pass per cycle sustained while out_ready holds; a pass
// moves on to the result register once that stage is free, and a stalled result
// stage still lets one more pass sit in the input register. Reset clears the
// pipeline, loads the register defaults and arms the boot countdown.
`default_nettype none

module alarm_tamper_supervisor
    import ats_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_we,
    input  wire cfg_index_t              cfg_index,
    input  wire logic [CfgDataWidth-1:0] cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    alarm_level,
    input  wire logic                    alarm_recheck,
    input  wire logic                    tamper_level,
    input  wire logic                    tamper_recheck,
    input  wire logic                    jumper_absent,
    input  wire logic                    battery_low,
    input  wire logic [ElapsedWidth-1:0] ticks_elapsed,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output msg_t                         alarm_message,
    output msg_t                         tamper_message,
    output logic                         supervisory_sent,
    output blink_t                       blink_count,
    output logic                         tamper_irq_enable,
    output logic                         led_force_off
);

    localparam logic [CountWidth-1:0] CountMax = '1;
    localparam logic [TickWidth-1:0]  TickMax  = '1;

    // configuration
    logic [TickWidth-1:0]  sup_period_reg;
    logic                  sup_enabled_reg;
    logic [CountWidth-1:0] restore_passes_reg;
    logic [CountWidth-1:0] boot_ignore_reg;
    logic [CountWidth-1:0] alarm_credit_reg;
    logic [CountWidth-1:0] test_credit_reg;

    // state
    logic                  alarm_latched_reg, alarm_latched_next;
    logic                  tamper_latched_reg, tamper_latched_next;
    logic                  boot_window_reg, boot_window_next;
    logic [CountWidth-1:0] boot_countdown_reg, boot_countdown_next;
    logic [CountWidth-1:0] restore_count_reg, restore_count_next;
    logic [CountWidth-1:0] open_count_reg, open_count_next;
    logic [TickWidth-1:0]  tick_total_reg, tick_total_next;
    logic                  irq_enabled_reg, irq_enabled_next;

    // input stage
    logic                    in_valid_reg;
    logic                    a_reg, ar_reg, t_reg, tr_reg, j_reg, low_reg;
    logic [ElapsedWidth-1:0] ticks_reg;

    // result stage
    logic   out_valid_reg;
    msg_t   alarm_message_reg, alarm_message_next;
    msg_t   tamper_message_reg, tamper_message_next;
    logic   sup_sent_reg, sup_sent_next;
    blink_t blink_reg, blink_next;
    logic   led_off_reg, led_off_next;

    logic                  advance;
    logic [CountWidth-1:0] credit;
    logic [TickWidth+1:0]  tick_sum;
    logic [TickWidth-1:0]  tick_sat;
    logic [CountWidth-1:0] cd_dec;
    logic [CountWidth-1:0] oc_inc;
    logic [CountWidth-1:0] rc_inc;
    logic                  closed_check;
    blink_t                blink_value;

    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_comb
    begin
        alarm_latched_next  = alarm_latched_reg;
        tamper_latched_next = tamper_latched_reg;
        boot_window_next    = boot_window_reg;
        boot_countdown_next = boot_countdown_reg;
        restore_count_next  = restore_count_reg;
        open_count_next     = open_count_reg;
        irq_enabled_next    = irq_enabled_reg;
        alarm_message_next  = ALARM_NONE;
        tamper_message_next = TAMPER_NONE;
        sup_sent_next       = 1'b0;
        blink_next          = BLINK_NONE;
        led_off_next        = 1'b0;
        credit              = '0;
        closed_check        = 1'b0;
        blink_value         = low_reg ? BLINK_LOW : BLINK_NORMAL;

        // alarm
        if (a_reg && !alarm_latched_reg && j_reg)
        begin
            if (ar_reg)
            begin
                alarm_message_next = ALARM_SENT;
                alarm_latched_next = 1'b1;
                credit             = alarm_credit_reg;
            end
        end
        else if (!a_reg && alarm_latched_reg && j_reg)
        begin
            if (!ar_reg)
                alarm_latched_next = 1'b0;
        end
        else if (a_reg && !j_reg)
        begin
            if (ar_reg)
            begin
                alarm_message_next = ALARM_TEST;
                credit             = test_credit_reg;
            end
        end

        // both additions saturate, so one three-input sum gives the same result
        tick_sum = {2'b00, tick_total_reg} + {{(TickWidth+2-ElapsedWidth){1'b0}}, ticks_reg}
                 + {{(TickWidth+2-CountWidth){1'b0}}, credit};
        tick_sat = (tick_sum[TickWidth+1:TickWidth] != 2'b00) ? TickMax
                                                               : tick_sum[TickWidth-1:0];

        // boot guard
        cd_dec = (boot_countdown_reg != '0) ? boot_countdown_reg - 1'b1 : boot_countdown_reg;
        if (boot_window_reg && !t_reg)
        begin
            boot_countdown_next = cd_dec;
            if (cd_dec == '0)
            begin
                boot_window_next = 1'b0;
                irq_enabled_next = 1'b1;
            end
        end
        else if (boot_window_reg && t_reg)
        begin
            boot_countdown_next = boot_ignore_reg;
            irq_enabled_next    = 1'b0;
        end

        // tamper
        oc_inc = (open_count_reg != CountMax) ? open_count_reg + 1'b1 : open_count_reg;
        rc_inc = (restore_count_reg != CountMax) ? restore_count_reg + 1'b1
                                                 : restore_count_reg;
        if (t_reg && !tamper_latched_reg && !boot_window_next)
        begin
            if (tr_reg)
            begin
                tamper_message_next = TAMPER_SENT;
                tamper_latched_next = 1'b1;
                restore_count_next  = '0;
            end
        end
        else if (t_reg && tamper_latched_reg)
        begin
            if (tr_reg)
            begin
                restore_count_next = '0;
                open_count_next    = oc_inc;
                if (oc_inc == CountWidth'(1))
                    blink_next = blink_value;
            end
            else
            begin
                closed_check = 1'b1;
            end
        end
        else if (!t_reg && tamper_latched_reg)
        begin
            closed_check = 1'b1;
        end

        if (closed_check)
        begin
            restore_count_next = rc_inc;
            open_count_next    = '0;
            if (rc_inc == CountWidth'(1))
                blink_next = blink_value;
            if (rc_inc >= restore_passes_reg)
            begin
                led_off_next        = 1'b1;
                restore_count_next  = '0;
                tamper_latched_next = 1'b0;
                tamper_message_next = TAMPER_RESTORE;
            end
        end

        // supervisory
        tick_total_next = tick_sat;
        if (tick_sat >= sup_period_reg)
        begin
            tick_total_next = '0;
            sup_sent_next   = sup_enabled_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sup_period_reg     <= RST_SUP_PERIOD;
            sup_enabled_reg    <= RST_SUP_ENABLED;
            restore_passes_reg <= RST_RESTORE;
            boot_ignore_reg    <= RST_BOOT_IGNORE;
            alarm_credit_reg   <= RST_ALARM_CREDIT;
            test_credit_reg    <= RST_TEST_CREDIT;
            alarm_latched_reg  <= 1'b0;
            tamper_latched_reg <= 1'b0;
            boot_window_reg    <= 1'b1;
            boot_countdown_reg <= RST_BOOT_IGNORE;
            restore_count_reg  <= '0;
            open_count_reg     <= '0;
            tick_total_reg     <= '0;
            irq_enabled_reg    <= 1'b0;
            in_valid_reg       <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SUP_PERIOD:   sup_period_reg     <= cfg_data[TickWidth-1:0];
                    REG_SUP_ENABLED:  sup_enabled_reg    <= cfg_data[0];
                    REG_RESTORE:      restore_passes_reg <= cfg_data[CountWidth-1:0];
                    REG_BOOT_IGNORE:  boot_ignore_reg    <= cfg_data[CountWidth-1:0];
                    REG_ALARM_CREDIT: alarm_credit_reg   <= cfg_data[CountWidth-1:0];
                    REG_TEST_CREDIT:  test_credit_reg    <= cfg_data[CountWidth-1:0];
                    default:          ;
                endcase
            end

            if (in_ready)
                in_valid_reg <= in_valid;

            if (advance)
            begin
                alarm_latched_reg  <= alarm_latched_next;
                tamper_latched_reg <= tamper_latched_next;
                boot_window_reg    <= boot_window_next;
                boot_countdown_reg <= boot_countdown_next;
                restore_count_reg  <= restore_count_next;
                open_count_reg     <= open_count_next;
                tick_total_reg     <= tick_total_next;
                irq_enabled_reg    <= irq_enabled_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            a_reg     <= alarm_level;
            ar_reg    <= alarm_recheck;
            t_reg     <= tamper_level;
            tr_reg    <= tamper_recheck;
            j_reg     <= jumper_absent;
            low_reg   <= battery_low;
            ticks_reg <= ticks_elapsed;
        end
        if (advance)
        begin
            alarm_message_reg  <= alarm_message_next;
            tamper_message_reg <= tamper_message_next;
            sup_sent_reg       <= sup_sent_next;
            blink_reg          <= blink_next;
            led_off_reg        <= led_off_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign alarm_message     = alarm_message_reg;
    assign tamper_message    = tamper_message_reg;
    assign supervisory_sent  = sup_sent_reg;
    assign blink_count       = blink_reg;
    assign tamper_irq_enable = irq_enabled_reg;
    assign led_force_off     = led_off_reg;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import ats_pkg::*;

    localparam int unsigned MaxWait      = 12;
    localparam int unsigned DrainCycles  = 6;
    localparam int unsigned PhasePasses  = 270;
    localparam int unsigned RandomPhases = 4;
    localparam int unsigned OpenBurst    = 40;
    localparam int unsigned ClosedBurst  = 40;
    localparam int unsigned HoldCycles   = 200;

    localparam cfg_index_t REG_SPARE_LO = 3'd6;
    localparam cfg_index_t REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic                    alarm_level;
        logic                    alarm_recheck;
        logic                    tamper_level;
        logic                    tamper_recheck;
        logic                    jumper_absent;
        logic                    battery_low;
        logic [ElapsedWidth-1:0] ticks_elapsed;
    } poll_t;

    localparam int unsigned PollBits = $bits(poll_t);

    typedef struct packed {
        msg_t   alarm_message;
        msg_t   tamper_message;
        logic   supervisory_sent;
        blink_t blink_count;
        logic   tamper_irq_enable;
        logic   led_force_off;
    } report_t;

    typedef enum logic {ROW_PASS, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t               kind;
        cfg_index_t              index;
        logic [CfgDataWidth-1:0] data;
        poll_t                   poll;
        logic                    typed;
        report_t                 report;
    } row_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    cfg_index_t              cfg_index = REG_SUP_PERIOD;
    logic [CfgDataWidth-1:0] cfg_data  = '0;
    logic                    in_valid  = 1'b0;
    poll_t                   poll_drv  = '0;
    logic                    out_ready = 1'b0;
    logic                    in_ready;
    logic                    out_valid;
    msg_t                    alarm_message;
    msg_t                    tamper_message;
    logic                    supervisory_sent;
    blink_t                  blink_count;
    logic                    tamper_irq_enable;
    logic                    led_force_off;

    // supervisor copy: registers and state
    logic [TickWidth-1:0]  sup_period;
    logic                  sup_enabled;
    logic [CountWidth-1:0] restore_passes;
    logic [CountWidth-1:0] boot_ignore;
    logic [CountWidth-1:0] alarm_credit;
    logic [CountWidth-1:0] test_credit;
    logic                  alarm_latched;
    logic                  tamper_latched;
    logic                  boot_window;
    logic                  irq_enabled;
    logic [CountWidth-1:0] boot_countdown;
    logic [CountWidth-1:0] restore_count;
    logic [CountWidth-1:0] open_count;
    logic [TickWidth-1:0]  tick_total;

    report_t     expected_reports[$];
    row_t        directed_rows[$];
    logic        quiet      = 1'b0;
    int unsigned hold_cycles = 0;
    logic        tamper_open = 1'b0;
    logic        alarm_active = 1'b0;
    int unsigned mismatch_count = 0;
    int unsigned compared_count = 0;
    int unsigned write_count = 0;
    int unsigned directed_count = 0;
    int unsigned burst_count = 0;
    int unsigned random_count = 0;

    alarm_tamper_supervisor u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .alarm_level       (poll_drv.alarm_level),
        .alarm_recheck     (poll_drv.alarm_recheck),
        .tamper_level      (poll_drv.tamper_level),
        .tamper_recheck    (poll_drv.tamper_recheck),
        .jumper_absent     (poll_drv.jumper_absent),
        .battery_low       (poll_drv.battery_low),
        .ticks_elapsed     (poll_drv.ticks_elapsed),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .alarm_message     (alarm_message),
        .tamper_message    (tamper_message),
        .supervisory_sent  (supervisory_sent),
        .blink_count       (blink_count),
        .tamper_irq_enable (tamper_irq_enable),
        .led_force_off     (led_force_off)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    initial
    begin
        #(3_000_000);
        $display("run timed out with %0d results outstanding", expected_reports.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    function automatic void reset_supervisor();
        sup_period     = RST_SUP_PERIOD;
        sup_enabled    = RST_SUP_ENABLED;
        restore_passes = RST_RESTORE;
        boot_ignore    = RST_BOOT_IGNORE;
        alarm_credit   = RST_ALARM_CREDIT;
        test_credit    = RST_TEST_CREDIT;
        alarm_latched  = 1'b0;
        tamper_latched = 1'b0;
        boot_window    = 1'b1;
        irq_enabled    = 1'b0;
        boot_countdown = RST_BOOT_IGNORE;
        restore_count  = '0;
        open_count     = '0;
        tick_total     = '0;
    endfunction

    function automatic void load_register(cfg_index_t idx, logic [CfgDataWidth-1:0] d);
        case (idx)
            REG_SUP_PERIOD:   sup_period     = d;
            REG_SUP_ENABLED:  sup_enabled    = d[0];
            REG_RESTORE:      restore_passes = d[CountWidth-1:0];
            REG_BOOT_IGNORE:  boot_ignore    = d[CountWidth-1:0];
            REG_ALARM_CREDIT: alarm_credit   = d[CountWidth-1:0];
            REG_TEST_CREDIT:  test_credit    = d[CountWidth-1:0];
            default: ;
        endcase
    endfunction

    function automatic logic [TickWidth-1:0] add_saturating(logic [TickWidth-1:0] total,
                                                           logic [TickWidth-1:0] n);
        logic [TickWidth:0] sum;
        sum = {1'b0, total} + {1'b0, n};
        return sum[TickWidth] ? '1 : sum[TickWidth-1:0];
    endfunction

    // one polling pass: tick credit, alarm, boot guard, tamper, supervisory
    function automatic report_t supervise_pass(poll_t p);
        report_t r;
        logic    closed_check;
        r.alarm_message     = ALARM_NONE;
        r.tamper_message    = TAMPER_NONE;
        r.supervisory_sent  = 1'b0;
        r.blink_count       = BLINK_NONE;
        r.led_force_off     = 1'b0;
        closed_check        = 1'b0;

        tick_total = add_saturating(tick_total, TickWidth'(p.ticks_elapsed));

        if (p.alarm_level && !alarm_latched && p.jumper_absent)
        begin
            if (p.alarm_recheck)
            begin
                r.alarm_message = ALARM_SENT;
                alarm_latched   = 1'b1;
                tick_total      = add_saturating(tick_total, TickWidth'(alarm_credit));
            end
        end
        else if (!p.alarm_level && alarm_latched && p.jumper_absent)
        begin
            if (!p.alarm_recheck)
                alarm_latched = 1'b0;
        end
        else if (p.alarm_level && !p.jumper_absent)
        begin
            if (p.alarm_recheck)
            begin
                r.alarm_message = ALARM_TEST;
                tick_total      = add_saturating(tick_total, TickWidth'(test_credit));
            end
        end

        if (boot_window && !p.tamper_level)
        begin
            if (boot_countdown != '0)
                boot_countdown = boot_countdown - 1'b1;
            if (boot_countdown == '0)
            begin
                boot_window = 1'b0;
                irq_enabled = 1'b1;
            end
        end
        else if (boot_window && p.tamper_level)
        begin
            boot_countdown = boot_ignore;
            irq_enabled    = 1'b0;
        end

        if (p.tamper_level && !tamper_latched && !boot_window)
        begin
            if (p.tamper_recheck)
            begin
                r.tamper_message = TAMPER_SENT;
                tamper_latched   = 1'b1;
                restore_count    = '0;
            end
        end
        else if (p.tamper_level && tamper_latched)
        begin
            if (p.tamper_recheck)
            begin
                restore_count = '0;
                if (open_count != '1)
                    open_count = open_count + 1'b1;
                if (open_count == 16'd1)
                    r.blink_count = p.battery_low ? BLINK_LOW : BLINK_NORMAL;
            end
            else
                closed_check = 1'b1;
        end
        else if (!p.tamper_level && tamper_latched)
            closed_check = 1'b1;

        if (closed_check)
        begin
            if (restore_count != '1)
                restore_count = restore_count + 1'b1;
            open_count = '0;
            if (restore_count == 16'd1)
                r.blink_count = p.battery_low ? BLINK_LOW : BLINK_NORMAL;
            if (restore_count >= restore_passes)
            begin
                r.led_force_off  = 1'b1;
                r.tamper_message = TAMPER_RESTORE;
                restore_count    = '0;
                tamper_latched   = 1'b0;
            end
        end

        if (tick_total >= sup_period)
        begin
            tick_total = '0;
            if (sup_enabled)
                r.supervisory_sent = 1'b1;
        end

        r.tamper_irq_enable = irq_enabled;
        return r;
    endfunction

    function automatic poll_t make_poll(int unsigned a, int unsigned ar, int unsigned t,
                                        int unsigned tr, int unsigned j, int unsigned low,
                                        logic [ElapsedWidth-1:0] ticks);
        return '{a[0], ar[0], t[0], tr[0], j[0], low[0], ticks};
    endfunction

    function automatic report_t make_report(msg_t am, msg_t tm, logic sup, blink_t b,
                                            logic irq, logic led);
        return '{am, tm, sup, b, irq, led};
    endfunction

    function automatic void row_pass(poll_t p, logic typed, report_t r);
        row_t row;
        row.kind   = ROW_PASS;
        row.index  = REG_SUP_PERIOD;
        row.data   = '0;
        row.poll   = p;
        row.typed  = typed;
        row.report = r;
        directed_rows.push_back(row);
    endfunction

    function automatic void row_write(cfg_index_t idx, logic [CfgDataWidth-1:0] d);
        row_t row;
        row.kind   = ROW_WRITE;
        row.index  = idx;
        row.data   = d;
        row.poll   = '0;
        row.typed  = 1'b0;
        row.report = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic int unsigned draw_wait();
        return quiet ? 0 : $urandom_range(MaxWait, 0);
    endfunction

    function automatic poll_t random_poll();
        poll_t p;
        if ($urandom_range(9, 0) == 0)
        begin
            p = PollBits'($urandom);
            return p;
        end
        if ($urandom_range(7, 0) == 0)
            tamper_open = !tamper_open;
        if ($urandom_range(4, 0) == 0)
            alarm_active = !alarm_active;
        p.tamper_level   = tamper_open;
        p.tamper_recheck = ($urandom_range(5, 0) == 0) ? !tamper_open : tamper_open;
        p.alarm_level    = alarm_active;
        p.alarm_recheck  = ($urandom_range(4, 0) == 0) ? !alarm_active : alarm_active;
        p.jumper_absent  = ($urandom_range(5, 0) != 0);
        p.battery_low    = 1'($urandom_range(1, 0));
        case ($urandom_range(3, 0))
            0:       p.ticks_elapsed = '0;
            1:       p.ticks_elapsed = '1;
            2:       p.ticks_elapsed = ElapsedWidth'($urandom_range(100, 0));
            default: p.ticks_elapsed = ElapsedWidth'($urandom);
        endcase
        return p;
    endfunction

    function automatic string describe(report_t r);
        return $sformatf("alarm=%0d tamper=%0d sup=%0d blink=%0d irq=%0d led_off=%0d",
                         r.alarm_message, r.tamper_message, r.supervisory_sent,
                         r.blink_count, r.tamper_irq_enable, r.led_force_off);
    endfunction

    // offer one pass, hold it until transfer, then idle for a drawn number of cycles
    task automatic offer_pass(input poll_t p, input logic typed, input report_t typed_report);
        report_t     predicted;
        int unsigned gap;
        poll_drv <= p;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = supervise_pass(p);
        expected_reports.push_back(typed ? typed_report : predicted);
        gap = draw_wait();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CfgDataWidth-1:0] d);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        @(posedge clk);
        load_register(idx, d);
        cfg_we <= 1'b0;
        @(posedge clk);
        write_count++;
    endtask

    initial
    begin : result_sink
        int unsigned stall;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall       = hold_cycles;
                hold_cycles = 0;
            end
            else
                stall = draw_wait();
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin : result_check
        report_t got;
        report_t want;
        got = '{alarm_message, tamper_message, supervisory_sent, blink_count,
                tamper_irq_enable, led_force_off};
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_reports.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with nothing expected: %s", describe(got));
            end
            else
            begin
                want = expected_reports.pop_front();
                compared_count++;
                if (got.alarm_message !== want.alarm_message ||
                    got.tamper_message !== want.tamper_message ||
                    got.supervisory_sent !== want.supervisory_sent ||
                    got.blink_count !== want.blink_count ||
                    got.tamper_irq_enable !== want.tamper_irq_enable ||
                    got.led_force_off !== want.led_force_off)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("result %0d: expected %s, got %s",
                                 compared_count, describe(want), describe(got));
                end
            end
        end
    end

    initial
    begin : stimulus
        poll_t   p;
        report_t idle_armed;
        reset_supervisor();
        idle_armed = make_report(ALARM_NONE, TAMPER_NONE, 1'b0, BLINK_NONE, 1'b1, 1'b0);

        // boot guard: reload while open, zero countdown arms on first closed pass
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b1,
                 make_report(ALARM_NONE, TAMPER_NONE, 1'b0, BLINK_NONE, 1'b0, 1'b0));
        row_pass(make_poll(0, 0, 1, 1, 1, 1, 16'hFFFF), 1'b1,
                 make_report(ALARM_NONE, TAMPER_NONE, 1'b0, BLINK_NONE, 1'b0, 1'b0));
        row_write(REG_BOOT_IGNORE, 32'd0);
        row_pass(make_poll(0, 0, 1, 0, 1, 0, 16'd0), 1'b1,
                 make_report(ALARM_NONE, TAMPER_NONE, 1'b0, BLINK_NONE, 1'b0, 1'b0));
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b1, idle_armed);
        // restore threshold zero: a bounce restores at once
        row_write(REG_RESTORE, 32'd0);
        row_pass(make_poll(0, 0, 1, 1, 1, 0, 16'd0), 1'b1,
                 make_report(ALARM_NONE, TAMPER_SENT, 1'b0, BLINK_NONE, 1'b1, 1'b0));
        row_pass(make_poll(0, 0, 1, 1, 1, 1, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 1, 1, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 1, 0, 1, 0, 16'd0), 1'b1,
                 make_report(ALARM_NONE, TAMPER_RESTORE, 1'b0, BLINK_NORMAL, 1'b1, 1'b1));
        row_write(REG_RESTORE, 32'd3);
        row_pass(make_poll(0, 0, 1, 1, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 0, 0, 1, 1, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 0, 1, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        // alarm latch and release, test jumper
        row_pass(make_poll(1, 0, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(1, 1, 0, 0, 1, 0, 16'hFFFF), 1'b0, '0);
        row_pass(make_poll(1, 1, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 1, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(1, 1, 0, 0, 0, 1, 16'd0), 1'b0, '0);
        row_pass(make_poll(1, 0, 0, 0, 0, 0, 16'd0), 1'b0, '0);
        // supervisory period zero, disabled, and one tick
        row_write(REG_SUP_PERIOD, 32'd0);
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b1,
                 make_report(ALARM_NONE, TAMPER_NONE, 1'b1, BLINK_NONE, 1'b1, 1'b0));
        row_write(REG_SUP_ENABLED, 32'd0);
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b1, idle_armed);
        row_write(REG_SUP_ENABLED, 32'd1);
        row_write(REG_SUP_PERIOD, 32'd1);
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(0, 0, 0, 0, 1, 0, 16'd1), 1'b1,
                 make_report(ALARM_NONE, TAMPER_NONE, 1'b1, BLINK_NONE, 1'b1, 1'b0));
        // writes to unused indexes change nothing
        row_write(REG_SPARE_LO, 32'hFFFF_FFFF);
        row_write(REG_SPARE_HI, 32'h0000_0000);
        row_write(REG_ALARM_CREDIT, 32'd0);
        row_write(REG_TEST_CREDIT, 32'h0000_FFFF);
        row_pass(make_poll(1, 1, 0, 0, 1, 0, 16'd0), 1'b0, '0);
        row_pass(make_poll(1, 1, 0, 0, 0, 0, 16'd0), 1'b0, '0);

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].kind == ROW_WRITE)
            begin
                settle();
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end
            else
            begin
                offer_pass(directed_rows[i].poll, directed_rows[i].typed,
                           directed_rows[i].report);
                directed_count++;
            end
        end

        // full-rate runs with every register at its maximum: open, then closed
        settle();
        write_reg(REG_SUP_PERIOD, 32'hFFFF_FFFF);
        write_reg(REG_SUP_ENABLED, 32'd1);
        write_reg(REG_RESTORE, 32'h0000_FFFF);
        write_reg(REG_BOOT_IGNORE, 32'h0000_FFFF);
        write_reg(REG_ALARM_CREDIT, 32'h0000_FFFF);
        write_reg(REG_TEST_CREDIT, 32'h0000_FFFF);
        quiet = 1'b1;
        for (int unsigned n = 0; n < OpenBurst; n++)
        begin
            offer_pass(make_poll(1, 1, 1, 1, 0, $urandom_range(1, 0), 16'hFFFF), 1'b0, '0);
            burst_count++;
        end
        for (int unsigned n = 0; n < ClosedBurst; n++)
        begin
            p = random_poll();
            p.tamper_level = 1'b0;
            offer_pass(p, 1'b0, '0);
            burst_count++;
        end
        quiet = 1'b0;

        for (int unsigned ph = 0; ph < RandomPhases; ph++)
        begin
            settle();
            case (ph)
                0:
                begin
                    write_reg(REG_SUP_PERIOD, $urandom_range(200000, 20000));
                    write_reg(REG_RESTORE, 32'd1);
                    write_reg(REG_ALARM_CREDIT, $urandom_range(65535, 0));
                    write_reg(REG_TEST_CREDIT, $urandom_range(65535, 0));
                end
                1:
                begin
                    write_reg(REG_SUP_PERIOD, 32'd1);
                    write_reg(REG_RESTORE, $urandom_range(8, 2));
                    write_reg(REG_ALARM_CREDIT, 32'd0);
                    write_reg(REG_TEST_CREDIT, 32'd0);
                end
                2:
                begin
                    write_reg(REG_SUP_PERIOD, $urandom);
                    write_reg(REG_RESTORE, $urandom_range(20, 3));
                    write_reg(REG_ALARM_CREDIT, 32'h0000_FFFF);
                    write_reg(REG_TEST_CREDIT, 32'h0000_FFFF);
                end
                default:
                begin
                    write_reg(REG_SUP_PERIOD, $urandom_range(1000000, 100000));
                    write_reg(REG_RESTORE, $urandom_range(6, 1));
                    write_reg(REG_ALARM_CREDIT, $urandom_range(3000, 0));
                    write_reg(REG_TEST_CREDIT, $urandom_range(3000, 0));
                end
            endcase
            write_reg(REG_SUP_ENABLED, (ph == 1) ? $urandom_range(1, 0) : 32'd1);
            write_reg(REG_BOOT_IGNORE, $urandom_range(65535, 0));
            write_reg(ph[0] ? REG_SPARE_HI : REG_SPARE_LO, $urandom);

            for (int unsigned n = 0; n < PhasePasses; n++)
            begin
                if (ph == 0 && n == 40)
                    hold_cycles = HoldCycles;
                if (ph == 1 && n == 150)
                    settle();
                quiet = (n >= 200 && n < 250);
                offer_pass(random_poll(), 1'b0, '0);
                random_count++;
            end
            quiet = 1'b0;
        end

        settle();
        if (expected_reports.size() != 0)
        begin
            mismatch_count += expected_reports.size();
            $display("%0d results never arrived", expected_reports.size());
        end
        $display("Passes: %0d directed, %0d in full-rate runs, %0d random; %0d register writes",
                 directed_count, burst_count, random_count, write_count);
        $display("Results checked: %0d, failures: %0d", compared_count, mismatch_count);
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
